// ===== hdl/psfs_pkg.sv =====
// shared types, constants and arithmetic helpers of the pointer sync filter and scaler
`default_nettype none
package psfs_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int POS_W      = 16;
    localparam int SIZE_W     = 16;
    localparam int TIME_W     = 32;
    localparam int RES_W      = 32;
    localparam int MAG_W      = POS_W + FRAC_BITS;
    localparam int PROD_W     = MAG_W + SIZE_W;
    localparam int CNT_W      = $clog2(PROD_W);
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 64;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;

    localparam logic [TIME_W-1:0] QUIET_MS      = 32'd250;
    localparam logic [SIZE_W-1:0] RESET_OUT_W   = 16'd1920;
    localparam logic [SIZE_W-1:0] RESET_OUT_H   = 16'd1080;
    localparam logic [PROD_W:0]   POS_LIMIT     = (PROD_W+1)'(33'h0_7FFF_FFFF);
    localparam logic [PROD_W:0]   NEG_LIMIT     = (PROD_W+1)'(33'h0_8000_0000);
    localparam logic [RES_W-1:0]  NEG_LIMIT_RES = 32'h8000_0000;
    localparam logic [RES_W-1:0]  POS_LIMIT_RES = 32'h7FFF_FFFF;

    typedef enum logic {
        CFG_OUTPUT_WIDTH  = 1'b0,
        CFG_OUTPUT_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } t_bstate;

    typedef struct packed {
        logic              neg_x;
        logic [MAG_W-1:0]  mag_x;
        logic [SIZE_W-1:0] num_x;
        logic [SIZE_W-1:0] den_x;
        logic              neg_y;
        logic [MAG_W-1:0]  mag_y;
        logic [SIZE_W-1:0] num_y;
        logic [SIZE_W-1:0] den_y;
    } t_job;

    typedef struct packed {
        logic [TIME_W-1:0] last_act;
        logic [SIZE_W-1:0] src_w;
        logic [SIZE_W-1:0] src_h;
        logic              primed;
        logic [POS_W-1:0]  prev_x;
        logic [POS_W-1:0]  prev_y;
        logic              injected;
        logic [POS_W-1:0]  sent_x;
        logic [POS_W-1:0]  sent_y;
    } t_fstate;

    typedef struct packed {
        logic [SIZE_W-1:0] rem;
        logic [PROD_W-1:0] quo;
    } t_div;

    // one restoring division step, dividend bits shift out of the top of quo
    function automatic t_div div_step(input logic [SIZE_W-1:0] rem,
                                      input logic [PROD_W-1:0] quo,
                                      input logic [SIZE_W-1:0] den);
        logic [SIZE_W:0] trial;
        logic            qbit;
        t_div            res;
        trial = {rem, quo[PROD_W-1]};
        qbit  = (trial >= {1'b0, den});
        if (qbit) begin
            res.rem = SIZE_W'(trial - {1'b0, den});
        end else begin
            res.rem = trial[SIZE_W-1:0];
        end
        res.quo = {quo[PROD_W-2:0], qbit};
        return res;
    endfunction

    // apply sign and saturate a magnitude to the signed result range
    function automatic logic [RES_W-1:0] sat_result(input logic neg,
                                                    input logic [PROD_W-1:0] mag);
        logic [PROD_W:0]  wide;
        logic [RES_W-1:0] lim;
        wide = {1'b0, mag};
        if (neg) begin
            if (wide > NEG_LIMIT) begin
                lim = NEG_LIMIT_RES;
            end else begin
                lim = mag[RES_W-1:0];
            end
            return RES_W'(~lim + 1'b1);
        end else begin
            if (wide > POS_LIMIT) begin
                return POS_LIMIT_RES;
            end else begin
                return mag[RES_W-1:0];
            end
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/psfs_front.sv =====
// front end: request intake, config registers, tracking state and the report decision
`default_nettype none
module psfs_front
    import psfs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [IN_USER_W-1:0] i_user,
    input  wire logic [IN_DATA_W-1:0] i_data,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_index,
    input  wire logic [SIZE_W-1:0]    i_cfg_data,
    output logic                      o_job_valid,
    output t_job                      o_job,
    input  wire logic                 i_job_ready
);

    t_fstate           r_st, n_st;
    logic [SIZE_W-1:0] r_out_w, r_out_h;

    logic              cmd, geo, ptr, accept;
    logic [TIME_W-1:0] now, idle_ms;
    logic [SIZE_W-1:0] sw, sh, eff_w, eff_h, ax, ay;
    logic [POS_W-1:0]  px, py;
    logic [POS_W:0]    dx, dy;
    logic              size_chg, eff_primed, eff_inj, same, origin;
    logic              quiet, near_x, near_y, far, emit, use_scale;

    always_comb begin
        cmd        = i_user[0];
        geo        = i_user[1];
        ptr        = i_user[2];
        now        = i_data[31:0];
        sw         = i_data[47:32];
        sh         = i_data[63:48];
        px         = i_data[79:64];
        py         = i_data[95:80];
        accept     = i_valid && i_job_ready;

        size_chg   = geo && ((sw != r_st.src_w) || (sh != r_st.src_h));
        eff_w      = size_chg ? sw : r_st.src_w;
        eff_h      = size_chg ? sh : r_st.src_h;
        eff_primed = r_st.primed && !size_chg;
        eff_inj    = r_st.injected && !size_chg;
        same       = (px == r_st.prev_x) && (py == r_st.prev_y);
        origin     = (px == '0) && (py == '0);
        idle_ms    = now - r_st.last_act;
        quiet      = idle_ms > QUIET_MS;
        dx         = {px[POS_W-1], px} - {r_st.sent_x[POS_W-1], r_st.sent_x};
        dy         = {py[POS_W-1], py} - {r_st.sent_y[POS_W-1], r_st.sent_y};
        near_x     = dx inside {17'h0_0000, 17'h0_0001, 17'h1_FFFF};
        near_y     = dy inside {17'h0_0000, 17'h0_0001, 17'h1_FFFF};
        far        = !eff_inj || !(near_x && near_y);
        emit       = cmd && ptr && eff_primed && !same && !origin && quiet && far;
        use_scale  = (eff_w != '0) && (eff_h != '0) && (r_out_w != '0) && (r_out_h != '0);

        ax = px[POS_W-1] ? POS_W'(~px + 1'b1) : px;
        ay = py[POS_W-1] ? POS_W'(~py + 1'b1) : py;

        o_ready     = i_job_ready;
        o_job_valid = accept && emit;
        o_job.neg_x = px[POS_W-1];
        o_job.mag_x = MAG_W'(ax) << FRAC_BITS;
        o_job.num_x = use_scale ? r_out_w : SIZE_W'(1);
        o_job.den_x = use_scale ? eff_w : SIZE_W'(1);
        o_job.neg_y = py[POS_W-1];
        o_job.mag_y = MAG_W'(ay) << FRAC_BITS;
        o_job.num_y = use_scale ? r_out_h : SIZE_W'(1);
        o_job.den_y = use_scale ? eff_h : SIZE_W'(1);

        n_st = r_st;
        if (accept) begin
            if (!cmd) begin
                n_st.last_act = now;
            end else begin
                if (size_chg) begin
                    n_st.src_w    = sw;
                    n_st.src_h    = sh;
                    n_st.primed   = 1'b0;
                    n_st.injected = 1'b0;
                end
                if (ptr) begin
                    if (!eff_primed) begin
                        n_st.primed = 1'b1;
                        n_st.prev_x = px;
                        n_st.prev_y = py;
                    end else if (!same) begin
                        n_st.prev_x = px;
                        n_st.prev_y = py;
                        if (emit) begin
                            n_st.injected = 1'b1;
                            n_st.sent_x   = px;
                            n_st.sent_y   = py;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '0;
            r_out_w <= RESET_OUT_W;
            r_out_h <= RESET_OUT_H;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_OUTPUT_WIDTH:  r_out_w <= i_cfg_data;
                    CFG_OUTPUT_HEIGHT: r_out_h <= i_cfg_data;
                    default:           r_out_w <= r_out_w;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/psfs_queue.sv =====
// two-entry job queue between front end and scaling engine
`default_nettype none
module psfs_queue
    import psfs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_not_full,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push, do_pop;

    always_comb begin
        o_not_full = r_cnt != (QPTR_W+1)'(QDEPTH);
        o_valid    = r_cnt != '0;
        o_job      = r_mem[r_rd];
        do_push    = i_push && o_not_full;
        do_pop     = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= QPTR_W'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= QPTR_W'(r_rd + 1'b1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/psfs_back.sv =====
// scaling engine: multiply, bit-serial divide on both axes, saturate, output register
`default_nettype none
module psfs_back
    import psfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_job_valid,
    input  t_job                       i_job,
    output logic                       o_job_pop,
    output logic                       o_tvalid,
    input  wire logic                  i_tready,
    output logic [OUT_DATA_W-1:0]      o_tdata
);

    t_bstate           r_state, n_state;
    t_job              r_job;
    logic [PROD_W-1:0] r_qx, r_qy;
    logic [SIZE_W-1:0] r_rx, r_ry;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic              out_free;
    t_div              stx, sty;

    always_comb begin
        out_free  = !r_ovalid || i_tready;
        o_job_pop = (r_state == ST_IDLE) && i_job_valid;
        stx       = div_step(r_rx, r_qx, r_job.den_x);
        sty       = div_step(r_ry, r_qy, r_job.den_y);
        o_tvalid  = r_ovalid;
        o_tdata   = r_odata;
        n_state   = r_state;
        case (r_state)
            ST_IDLE: if (i_job_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (r_cnt == '0) n_state = ST_HOLD;
            ST_HOLD: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: r_job <= i_job;
            ST_MUL: begin
                r_qx  <= PROD_W'(r_job.mag_x) * PROD_W'(r_job.num_x);
                r_qy  <= PROD_W'(r_job.mag_y) * PROD_W'(r_job.num_y);
                r_rx  <= '0;
                r_ry  <= '0;
                r_cnt <= CNT_W'(PROD_W - 1);
            end
            ST_DIV: begin
                r_qx  <= stx.quo;
                r_rx  <= stx.rem;
                r_qy  <= sty.quo;
                r_ry  <= sty.rem;
                r_cnt <= r_cnt - 1'b1;
            end
            default: r_cnt <= r_cnt;
        endcase
        if ((r_state == ST_HOLD) && out_free) begin
            r_odata <= {sat_result(r_job.neg_y, r_qy), sat_result(r_job.neg_x, r_qx)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_HOLD) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pointer_sync_filter_scaler.sv =====
// top level of the pointer sync filter and scaler
// usage:
//   slave stream carries activity notes and pointer polls; a request is taken when
//   s_axis_tvalid and s_axis_tready are high. a note only records its timestamp, a poll
//   may update the held source size and the tracked position.
//   the config channel writes output_width (index 0) or output_height (index 1)
//   on i_cfg_valid; o_cfg_ready is always high. write it only while the block idles.
//   a poll that passes the filter produces one scaled position on the master stream:
//   it is written into the job queue, latched by the engine, multiplied, then divided
//   by one restoring-divide step per product bit (both axes in parallel), and
//   saturated into the output register.
//   notes and filtered-out polls are taken every cycle while the job queue has room;
//   reporting polls are taken back to back while the two-entry job queue has room;
//   the serial divider sets the sustained rate; the engine takes no job until the last is out.
//   when the master side stalls, the result waits in the output register, the
//   engine holds its next result and the queue fills, then s_axis_tready drops.
//   reset restores output size 1920 x 1080, clears all tracking state and the queue.
`default_nettype none
module pointer_sync_filter_scaler
    import psfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // time_ms[31:0], source_width[47:32], source_height[63:48], pos_x[79:64], pos_y[95:80]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[0], geometry_valid[1], pointer_valid[2]
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // scaled_x[31:0], scaled_y[63:32]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_index,
    input  wire logic [SIZE_W-1:0]     i_cfg_data
);

    logic job_push, job_not_full, job_valid, job_pop;
    t_job push_job, pop_job;

    assign o_cfg_ready = 1'b1;

    psfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_user      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (job_push),
        .o_job       (push_job),
        .i_job_ready (job_not_full)
    );

    psfs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (job_push),
        .i_job      (push_job),
        .o_not_full (job_not_full),
        .o_valid    (job_valid),
        .o_job      (pop_job),
        .i_pop      (job_pop)
    );

    psfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (pop_job),
        .o_job_pop   (job_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== hdl/psfs_checker.sv =====
// port-level checks of the pointer sync filter and scaler, bound to the top level
`default_nettype none
module psfs_checker
    import psfs_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty after reset");

    a_no_early_result: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("result appeared faster than the scaling engine allows");

endmodule

bind pointer_sync_filter_scaler psfs_checker u_psfs_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
// self-checking testbench of the pointer sync filter and scaler
`default_nettype none
module tb;
    import psfs_pkg::*;

    localparam bit CMD_NOTE   = 1'b0;
    localparam bit CMD_POLL   = 1'b1;
    localparam int NEAR_DIST  = 2;
    localparam int SETTLE_CYC = 60;
    localparam int PHASE_REQS = 325;

    typedef struct {
        bit               cmd;
        bit [31:0]        stamp;
        bit               geo_v;
        bit [15:0]        src_w;
        bit [15:0]        src_h;
        bit               ptr_v;
        bit signed [15:0] px;
        bit signed [15:0] py;
    } t_request;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] x;
    } t_report;

    class pointer_report_board;
        bit [15:0]        out_w = RESET_OUT_W;
        bit [15:0]        out_h = RESET_OUT_H;
        bit [31:0]        last_act;
        bit [15:0]        src_w;
        bit [15:0]        src_h;
        bit               primed;
        bit               injected;
        bit signed [15:0] prev_x;
        bit signed [15:0] prev_y;
        bit signed [15:0] sent_x;
        bit signed [15:0] sent_y;
        t_report          pending_reports[$];
        int unsigned      failures;

        function void write_output_size(t_cfg_idx idx, bit [15:0] value);
            if (idx == CFG_OUTPUT_WIDTH) begin
                out_w = value;
            end else begin
                out_h = value;
            end
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction

        function logic [31:0] scaled_axis(bit signed [15:0] p, bit [15:0] num,
                                          bit [15:0] den, bit en);
            longint unsigned mag;
            bit              neg;
            neg = p < 0;
            mag = neg ? 64'(-int'(p)) : 64'(int'(p));
            mag = mag << FRAC_BITS;
            if (en) begin
                mag = mag * num / den;
            end
            if (neg) begin
                if (mag > 64'h8000_0000) begin
                    mag = 64'h8000_0000;
                end
                return 32'(~mag[31:0] + 32'd1);
            end
            if (mag > 64'h7FFF_FFFF) begin
                return 32'h7FFF_FFFF;
            end
            return mag[31:0];
        endfunction

        function void take_request(t_request r);
            bit [31:0] quiet_for;
            int        dx;
            int        dy;
            bit        far;
            bit        en;
            t_report   rep;
            if (r.cmd == CMD_NOTE) begin
                last_act = r.stamp;
                return;
            end
            if (r.geo_v && (r.src_w != src_w || r.src_h != src_h)) begin
                src_w    = r.src_w;
                src_h    = r.src_h;
                primed   = 1'b0;
                injected = 1'b0;
            end
            if (!r.ptr_v) begin
                return;
            end
            if (!primed) begin
                primed = 1'b1;
                prev_x = r.px;
                prev_y = r.py;
                return;
            end
            if (r.px == prev_x && r.py == prev_y) begin
                return;
            end
            prev_x = r.px;
            prev_y = r.py;
            if (r.px == 0 && r.py == 0) begin
                return;
            end
            quiet_for = r.stamp - last_act;
            dx = int'(r.px) - int'(sent_x);
            dy = int'(r.py) - int'(sent_y);
            far = !injected || dx >= NEAR_DIST || dx <= -NEAR_DIST ||
                  dy >= NEAR_DIST || dy <= -NEAR_DIST;
            if (quiet_for <= QUIET_MS || !far) begin
                return;
            end
            en = src_w != 0 && src_h != 0 && out_w != 0 && out_h != 0;
            rep.x = scaled_axis(r.px, out_w, src_w, en);
            rep.y = scaled_axis(r.py, out_h, src_h, en);
            pending_reports.push_back(rep);
            injected = 1'b1;
            sent_x   = r.px;
            sent_y   = r.py;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void check_report(logic [63:0] data);
            t_report want;
            if (pending_reports.size() == 0) begin
                note_failure($sformatf("unexpected report x=%0d y=%0d",
                                       $signed(data[31:0]), $signed(data[63:32])));
                return;
            end
            want = pending_reports.pop_front();
            if (data[31:0] !== want.x) begin
                note_failure($sformatf("scaled_x mismatch: expected %0d got %0d",
                                       $signed(want.x), $signed(data[31:0])));
            end
            if (data[63:32] !== want.y) begin
                note_failure($sformatf("scaled_y mismatch: expected %0d got %0d",
                                       $signed(want.y), $signed(data[63:32])));
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index   = CFG_OUTPUT_WIDTH;
    logic [SIZE_W-1:0]     i_cfg_data    = '0;

    pointer_report_board board;
    bit [31:0]           now_ms;
    bit                  idle_on    = 1'b1;
    int unsigned         stall_left = 0;

    always #5 i_clk = ~i_clk;

    pointer_sync_filter_scaler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 20) begin
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_report(m_axis_tdata);
        end
    end

    task automatic send_request(t_request r);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.py, r.px, r.src_h, r.src_w, r.stamp};
        s_axis_tuser  <= {r.ptr_v, r.geo_v, r.cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.take_request(r);
        gap = (idle_on && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off the stream until every report is out and the engine is quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_output_size(bit [15:0] w, bit [15:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_OUTPUT_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_output_size(CFG_OUTPUT_WIDTH, w);
        i_cfg_index <= CFG_OUTPUT_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_output_size(CFG_OUTPUT_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_request activity(bit [31:0] stamp);
        t_request r;
        r.cmd   = CMD_NOTE;
        r.stamp = stamp;
        r.geo_v = 1'b1;
        r.src_w = 16'hFFFF;
        r.src_h = 16'hFFFF;
        r.ptr_v = 1'b1;
        r.px    = -16'sd1;
        r.py    = -16'sd1;
        return r;
    endfunction

    function automatic t_request poll(bit [31:0] stamp, bit geo_v, bit [15:0] w, bit [15:0] h,
                                      bit ptr_v, bit signed [15:0] x, bit signed [15:0] y);
        t_request r;
        r.cmd   = CMD_POLL;
        r.stamp = stamp;
        r.geo_v = geo_v;
        r.src_w = w;
        r.src_h = h;
        r.ptr_v = ptr_v;
        r.px    = x;
        r.py    = y;
        return r;
    endfunction

    function automatic bit signed [15:0] corner_pos();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       roll;
        r.cmd   = CMD_POLL;
        r.geo_v = 1'($urandom_range(0, 1));
        r.src_w = 16'($urandom);
        r.src_h = 16'($urandom);
        r.px    = 16'($urandom);
        r.py    = 16'($urandom);
        if ($urandom_range(0, 99) < 2) begin
            now_ms = $urandom;
        end else begin
            now_ms = now_ms + $urandom_range(1, 120);
        end
        r.stamp = now_ms;
        r.ptr_v = $urandom_range(0, 99) < 92;
        if ($urandom_range(0, 99) < 8) begin
            r.cmd = CMD_NOTE;
            return r;
        end
        r.geo_v = $urandom_range(0, 99) < 60;
        if (r.geo_v) begin
            roll = $urandom_range(0, 99);
            if (roll >= 5) begin
                r.src_w = board.src_w;
                r.src_h = board.src_h;
            end else begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: begin
                        r.src_w = 16'($urandom_range(1, 64));
                        r.src_h = 16'($urandom_range(1, 64));
                    end
                    2: begin
                        if ($urandom_range(0, 1)) r.src_w = 16'd0;
                        else r.src_h = 16'd0;
                    end
                    default: begin
                        r.src_w = 16'hFFFF;
                        r.src_h = 16'hFFFF;
                    end
                endcase
            end
        end
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
        end else if (roll < 65) begin
            r.px = board.sent_x + 16'($urandom_range(0, 6) - 3);
            r.py = board.sent_y + 16'($urandom_range(0, 6) - 3);
        end else if (roll < 75) begin
            r.px = board.prev_x;
            r.py = board.prev_y;
        end else if (roll < 80) begin
            r.px = 16'sd0;
            r.py = 16'sd0;
        end else if (roll < 90) begin
            r.px = corner_pos();
            r.py = corner_pos();
        end else begin
            r.px = 16'($urandom_range(0, 100) - 50);
            r.py = 16'($urandom_range(0, 100) - 50);
        end
        return r;
    endfunction

    task automatic directed_requests();
        send_request(activity(32'd1000));
        send_request(poll(32'd1300, 1, 16'd800, 16'd600, 1, 16'sd10, 16'sd10));
        send_request(poll(32'd1400, 0, 16'd0, 16'd0, 1, 16'sd10, 16'sd10));
        send_request(poll(32'd1450, 1, 16'd800, 16'd600, 1, 16'sd0, 16'sd0));
        send_request(poll(32'd1500, 0, 16'd0, 16'd0, 1, 16'sd100, 16'sd50));
        send_request(poll(32'd1520, 0, 16'd0, 16'd0, 1, 16'sd101, 16'sd50));
        send_request(poll(32'd1540, 0, 16'd0, 16'd0, 1, 16'sd102, 16'sd50));
        send_request(poll(32'd1560, 0, 16'd0, 16'd0, 0, 16'sd500, 16'sd500));
        send_request(activity(32'd2000));
        send_request(poll(32'd2100, 0, 16'd0, 16'd0, 1, 16'sd300, 16'sd300));
        send_request(poll(32'd2250, 0, 16'd0, 16'd0, 1, 16'sd305, 16'sd300));
        send_request(poll(32'd2251, 0, 16'd0, 16'd0, 1, 16'sd306, 16'sd300));
        send_request(poll(32'd2300, 0, 16'd0, 16'd0, 1, 16'sd32767, 16'sd32767));
        send_request(poll(32'd2320, 0, 16'd0, 16'd0, 1, -16'sd32768, -16'sd32768));
        // tiny source size drives both axes into saturation
        send_request(poll(32'd2340, 1, 16'd1, 16'd1, 1, 16'sd5, 16'sd5));
        send_request(poll(32'd2360, 0, 16'd0, 16'd0, 1, 16'sd32767, -16'sd32768));
        send_request(poll(32'd2380, 1, 16'd0, 16'd600, 1, 16'sd7, 16'sd7));
        send_request(poll(32'd2400, 0, 16'd0, 16'd0, 1, -16'sd9, 16'sd40));
        send_request(poll(32'd2420, 1, 16'hFFFF, 16'hFFFF, 0, 16'sd3, 16'sd3));
        send_request(poll(32'd2440, 0, 16'd0, 16'd0, 1, 16'sd1, 16'sd1));
        send_request(poll(32'd2460, 0, 16'd0, 16'd0, 1, -16'sd1, -16'sd1));
        send_request(poll(32'd2480, 0, 16'd0, 16'd0, 1, -16'sd2, -16'sd1));
        // quiet interval measured across the timestamp wrap
        send_request(activity(32'hFFFF_FF00));
        send_request(poll(32'h0000_0010, 0, 16'd0, 16'd0, 1, -16'sd3, -16'sd1));
        send_request(poll(32'h0000_0020, 1, 16'hFFFF, 16'hFFFF, 1, 16'sd200, 16'sd200));
        now_ms = 32'h0000_0020;
    endtask

    initial begin
        #25_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        bit [15:0] w;
        bit [15:0] h;
        board = new;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_requests();
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin w = 16'd1920;  h = 16'd1080;  end
                1: begin w = 16'hFFFF;  h = 16'hFFFF;  end
                2: begin w = 16'd0;     h = 16'd1080;  end
                3: begin w = 16'd1;     h = 16'd1;     end
                4: begin w = 16'd640;   h = 16'd0;     end
                default: begin w = 16'($urandom); h = 16'($urandom); end
            endcase
            set_output_size(w, h);
            idle_on = (phase % 3) != 1;
            repeat (PHASE_REQS) send_request(random_request());
        end
        drain();
        if (board.failures == 0 && board.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== pointer_sync_filter_scaler.f =====
hdl/psfs_pkg.sv
hdl/psfs_front.sv
hdl/psfs_queue.sv
hdl/psfs_back.sv
hdl/pointer_sync_filter_scaler.sv
hdl/psfs_checker.sv
bench/tb.sv
